// ----- sv/cfbr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfbr_pkg: shared types and constants of the closest front/back range block
// Coordinate and distance widths, reset values, controller state encoding and
// the command/status words that pass between controller and datapath.
// ----------------------------------------------------------------------------
package cfbr_pkg;

   // coordinate width; squares and minima are twice as wide
   localparam int COORD_BITS = 18;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int ROOT_BITS  = COORD_BITS;
   localparam int OOR_BITS   = 17;
   localparam int DIST_BITS  = 18;
   localparam int CNT_BITS   = $clog2(ROOT_BITS);

   // out-of-range distance after reset and its square
   localparam logic [OOR_BITS-1:0] OOR_RESET    = 17'd100000;
   localparam logic [SQ_BITS-1:0]  OOR_SQ_RESET = SQ_BITS'(OOR_RESET) * SQ_BITS'(OOR_RESET);

   typedef enum logic [1:0] {
      ST_STREAM,
      ST_WAIT,
      ST_ROOT,
      ST_SEND
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic load_root;
      logic step_root;
   } dp_cmd_type;

   typedef struct packed {
      logic last_in_stage;
   } dp_status_type;

endpackage

// ----- sv/cfbr_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfbr_req_if: point input channel
// One word is one scan point: x, y and the end-of-scan flag.
// ----------------------------------------------------------------------------
interface cfbr_req_if;
   import cfbr_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic                         last_point;

   modport source (output valid, output point_x, output point_y, output last_point,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input last_point,
                   output ready);
endinterface

// ----- sv/cfbr_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfbr_rsp_if: range result channel
// One word per scan: closest front and back distances in millimeters.
// ----------------------------------------------------------------------------
interface cfbr_rsp_if;
   import cfbr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [DIST_BITS-1:0] front_distance;
   logic [DIST_BITS-1:0] back_distance;

   modport source (output valid, output front_distance, output back_distance,
                   input ready);
   modport sink   (input valid, input front_distance, input back_distance,
                   output ready);
endinterface

// ----- sv/cfbr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfbr_ctrl: sequencing controller
// Streams points, waits for the end-of-scan point to settle the minima, runs
// the root iterations and holds the result until it is taken.
// ----------------------------------------------------------------------------
module cfbr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  cfbr_pkg::dp_status_type status,
   output cfbr_pkg::dp_cmd_type    cmd
);
   import cfbr_pkg::*;

   ctrl_state_type      state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   // state and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_STREAM;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd.accept    = 1'b0;
      cmd.load_root = 1'b0;
      cmd.step_root = 1'b0;
      case (state_ff)
         ST_STREAM: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (status.last_in_stage) begin
               cmd.load_root = 1'b1;
               cnt_in        = '0;
               state_in      = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cmd.step_root = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(ROOT_BITS - 1)) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_STREAM;
            end
         end
         default: begin
            state_in = ST_STREAM;
         end
      endcase
   end

endmodule

// ----- sv/cfbr_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfbr_isqrt: bit-serial integer square root
// Produces one root bit per step from the top bit pair of the radicand down;
// after ROOT_BITS steps the root register holds the floor of the root.
// ----------------------------------------------------------------------------
module cfbr_isqrt (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          step,
   input  logic [cfbr_pkg::SQ_BITS-1:0]  operand,
   output logic [cfbr_pkg::ROOT_BITS-1:0] root
);
   import cfbr_pkg::*;

   logic [SQ_BITS-1:0]   rad_ff, rad_in;
   logic [ROOT_BITS:0]   rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [ROOT_BITS+2:0] rem_shift;
   logic [ROOT_BITS+2:0] trial;
   logic [ROOT_BITS+2:0] diff;

   // one digit step: bring down a bit pair, try root*4+1
   always_comb begin
      rem_shift = {rem_ff, rad_ff[SQ_BITS-1 -: 2]};
      trial     = {1'b0, root_ff, 2'b01};
      diff      = rem_shift - trial;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      if (load) begin
         rad_in  = operand;
         rem_in  = '0;
         root_in = '0;
      end else if (step) begin
         rad_in = {rad_ff[SQ_BITS-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = diff[ROOT_BITS:0];
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[ROOT_BITS:0];
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
      end
   end

   // hold the iteration state
   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;

endmodule

// ----- sv/cfbr_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfbr_dpath: distance datapath
// Squares the coordinates in one stage, adds and updates the front/back
// minima in the next, reloads them at scan end or on a range write and feeds the two roots.
// ----------------------------------------------------------------------------
module cfbr_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  cfbr_pkg::dp_cmd_type                cmd,
   output cfbr_pkg::dp_status_type             status,
   input  logic signed [cfbr_pkg::COORD_BITS-1:0] point_x,
   input  logic signed [cfbr_pkg::COORD_BITS-1:0] point_y,
   input  logic                                last_point,
   input  logic                                csr_we,
   input  logic [cfbr_pkg::OOR_BITS-1:0]       csr_wdata,
   output logic [cfbr_pkg::DIST_BITS-1:0]      front_distance,
   output logic [cfbr_pkg::DIST_BITS-1:0]      back_distance
);
   import cfbr_pkg::*;

   logic [COORD_BITS-1:0] mag_x, mag_y;
   logic                  s1_valid_ff, s1_last_ff, s1_front_ff, s1_back_ff;
   logic [SQ_BITS-1:0]    sq_x_ff, sq_y_ff;
   logic [SQ_BITS-1:0]    oor_sq_ff, oor_sq_in;
   logic [SQ_BITS-1:0]    min_front_ff, min_front_in;
   logic [SQ_BITS-1:0]    min_back_ff, min_back_in;
   logic [SQ_BITS-1:0]    upd_front, upd_back;
   logic [SQ_BITS-1:0]    dist_sq;
   logic [ROOT_BITS-1:0]  root_front, root_back;

   // take magnitudes; the most negative code maps to its unsigned value
   assign mag_x = point_x[COORD_BITS-1] ? unsigned'(-point_x) : unsigned'(point_x);
   assign mag_y = point_y[COORD_BITS-1] ? unsigned'(-point_y) : unsigned'(point_y);

   // square stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.accept;
      end
      if (cmd.accept) begin
         sq_x_ff     <= SQ_BITS'(mag_x) * SQ_BITS'(mag_x);
         sq_y_ff     <= SQ_BITS'(mag_y) * SQ_BITS'(mag_y);
         s1_last_ff  <= last_point;
         s1_front_ff <= !point_x[COORD_BITS-1] && (point_x != '0);
         s1_back_ff  <= point_x[COORD_BITS-1];
      end
   end

   assign status.last_in_stage = s1_valid_ff && s1_last_ff;

   // add and keep the smaller square per side
   always_comb begin
      dist_sq   = sq_x_ff + sq_y_ff;
      upd_front = min_front_ff;
      upd_back  = min_back_ff;
      if (s1_valid_ff && s1_front_ff && (dist_sq < min_front_ff)) begin
         upd_front = dist_sq;
      end
      if (s1_valid_ff && s1_back_ff && (dist_sq < min_back_ff)) begin
         upd_back = dist_sq;
      end
      oor_sq_in    = oor_sq_ff;
      min_front_in = upd_front;
      min_back_in  = upd_back;
      if (csr_we) begin
         oor_sq_in    = SQ_BITS'(csr_wdata) * SQ_BITS'(csr_wdata);
         min_front_in = oor_sq_in;
         min_back_in  = oor_sq_in;
      end else if (status.last_in_stage) begin
         min_front_in = oor_sq_ff;
         min_back_in  = oor_sq_ff;
      end
   end

   // minima and range square
   always_ff @(posedge clock) begin
      if (reset) begin
         oor_sq_ff    <= OOR_SQ_RESET;
         min_front_ff <= OOR_SQ_RESET;
         min_back_ff  <= OOR_SQ_RESET;
      end else begin
         oor_sq_ff    <= oor_sq_in;
         min_front_ff <= min_front_in;
         min_back_ff  <= min_back_in;
      end
   end

   // roots of the closing minima
   cfbr_isqrt u_root_front (
      .clock   (clock),
      .load    (cmd.load_root),
      .step    (cmd.step_root),
      .operand (upd_front),
      .root    (root_front)
   );

   cfbr_isqrt u_root_back (
      .clock   (clock),
      .load    (cmd.load_root),
      .step    (cmd.step_root),
      .operand (upd_back),
      .root    (root_back)
   );

   assign front_distance = DIST_BITS'(root_front);
   assign back_distance  = DIST_BITS'(root_back);

endmodule

// ----- sv/closest_front_back_range.sv -----
`timescale 1ns / 1ps
// Points stream in at one word per cycle while no scan result is pending; each
// updates the minima in the cycle after it is taken (squares registered at
// acceptance, then add/compare stage). A last point offers its result word once
// the minima settle and both roots load, then after 18 root steps.
// No new point is taken from a last point until its result word is taken.
// Synchronous reset restores a 100000 mm range and reloads both minima at once.
// ----------------------------------------------------------------------------
// closest_front_back_range: closest front and back lidar range per scan
// Tracks the smallest squared planar distance ahead of and behind the sensor
// and reports both as integer square roots at the end of each scan.
// ----------------------------------------------------------------------------
module closest_front_back_range (
   input  logic                          clock,
   input  logic                          reset,
   cfbr_req_if.sink                      req,
   cfbr_rsp_if.source                    rsp,
   input  logic                          csr_we,
   input  logic [cfbr_pkg::OOR_BITS-1:0] csr_wdata
);
   import cfbr_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing
   cfbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.last_point),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic
   cfbr_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .point_x        (req.point_x),
      .point_y        (req.point_y),
      .last_point     (req.last_point),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .front_distance (rsp.front_distance),
      .back_distance  (rsp.back_distance)
   );

   // stop taking points once a last point is in
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.last_point |=> !req.ready)
      else $error("point accepted right after a last point");

   // result word follows a last point after the root run
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.last_point |-> ##(ROOT_BITS + 2) rsp.valid)
      else $error("result word not ready after root run");

   // no point taken while a result word waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("input open while result pending");

   // one result word per scan
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready |=> !rsp.valid)
      else $error("result word repeated");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for closest_front_back_range
// Streams lidar scans into the point channel and predicts the closest front
// and back range of each scan. Every result word is checked field by field
// against the oldest prediction. Directed scans cover the coordinate
// extremes and the corner ranges; random scans follow in four traffic phases.
// ----------------------------------------------------------------------------
module tb;
   import cfbr_pkg::*;

   localparam int RESULT_LATENCY = 20;
   localparam int SETTLE_CYCLES  = RESULT_LATENCY + 8;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct {
      logic [DIST_BITS-1:0] front;
      logic [DIST_BITS-1:0] back;
   } range_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                csr_we;
   logic [OOR_BITS-1:0] csr_wdata;

   cfbr_req_if req_ch ();
   cfbr_rsp_if rsp_ch ();

   closest_front_back_range DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predicted state of the range tracker
   logic [OOR_BITS-1:0] range_mm;
   logic [SQ_BITS-1:0]  front_min_sq;
   logic [SQ_BITS-1:0]  back_min_sq;
   range_pair_type      expected_ranges[$];

   int error_count  = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;

   // clock: 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic logic [SQ_BITS-1:0] planar_square(logic signed [COORD_BITS-1:0] x,
                                                       logic signed [COORD_BITS-1:0] y);
      longint sx;
      longint sy;
      sx = x;
      sy = y;
      return SQ_BITS'(sx * sx + sy * sy);
   endfunction

   // floor root, built one bit at a time from the top
   function automatic logic [DIST_BITS-1:0] floor_root(logic [SQ_BITS-1:0] n);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int i = DIST_BITS - 1; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= longint'(n))
            root = trial;
      end
      return DIST_BITS'(root);
   endfunction

   function automatic void reload_minima();
      logic [SQ_BITS-1:0] sq;
      sq = SQ_BITS'(range_mm) * SQ_BITS'(range_mm);
      front_min_sq = sq;
      back_min_sq  = sq;
   endfunction

   // fold one accepted point into the minima; queue a result on the last one
   function automatic void track_point(logic signed [COORD_BITS-1:0] x,
                                       logic signed [COORD_BITS-1:0] y, logic last);
      logic [SQ_BITS-1:0] dsq;
      range_pair_type     pair;
      dsq = planar_square(x, y);
      if (x > 0 && dsq < front_min_sq)
         front_min_sq = dsq;
      if (x < 0 && dsq < back_min_sq)
         back_min_sq = dsq;
      if (last) begin
         pair.front = floor_root(front_min_sq);
         pair.back  = floor_root(back_min_sq);
         expected_ranges = {expected_ranges, pair};
         reload_minima();
      end
   endfunction

   // ------------------------------------------------------------------------
   // result side: check each word, then roll the stall for the next cycle
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      range_pair_type want;
      if (rsp_ch.valid && rsp_ch.ready) begin
         if (expected_ranges.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual front %0d back %0d",
                     $time, rsp_ch.front_distance, rsp_ch.back_distance);
            error_count++;
         end else begin
            want = expected_ranges.pop_front();
            if (rsp_ch.front_distance !== want.front) begin
               $display("%0t: front_distance expected %0d, actual %0d",
                        $time, want.front, rsp_ch.front_distance);
               error_count++;
            end
            if (rsp_ch.back_distance !== want.back) begin
               $display("%0t: back_distance expected %0d, actual %0d",
                        $time, want.back, rsp_ch.back_distance);
               error_count++;
            end
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // shared drivers
   // ------------------------------------------------------------------------
   // offer one point word, after a random idle gap, and hold it until taken
   task automatic send_point(logic signed [COORD_BITS-1:0] x,
                             logic signed [COORD_BITS-1:0] y, logic last);
      int gap;
      gap = 0;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.point_x    <= x;
      req_ch.point_y    <= y;
      req_ch.last_point <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      track_point(x, y, last);
   endtask

   // drop valid, drain all results and let the pipeline settle
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_ranges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_range(logic [OOR_BITS-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      range_mm = value;
      reload_minima();
   endtask

   // random coordinate: mostly within the current range, with full-width,
   // zero and extreme values mixed in
   function automatic logic signed [COORD_BITS-1:0] pick_coord(int unsigned span);
      int unsigned pick;
      int          v;
      pick = $urandom_range(99);
      if (pick < 10)
         v = 0;
      else if (pick < 35)
         v = int'($urandom);
      else if (pick < 40)
         case ($urandom_range(3))
            0: v = -(1 << (COORD_BITS - 1));
            1: v = (1 << (COORD_BITS - 1)) - 1;
            2: v = -1;
            default: v = 1;
         endcase
      else
         v = int'($urandom_range(2 * span)) - int'(span);
      return COORD_BITS'(v);
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // a scan with no point on either side reports the reset range
   task automatic test_empty_scan();
      send_point(18'sd0, 18'sd77, 1'b1);
      send_point(18'sd0, -18'sd131072, 1'b0);
      send_point(18'sd0, 18'sd131071, 1'b1);
      wait_idle();
   endtask

   // full-scale coordinates never beat the largest range; tiny ones do
   task automatic test_coordinate_extremes();
      write_range(17'd131071);
      send_point(18'sd131071, -18'sd131072, 1'b0);
      send_point(-18'sd131072, 18'sd131071, 1'b0);
      send_point(-18'sd131072, -18'sd131072, 1'b1);
      send_point(18'sd131071, 18'sd0, 1'b0);
      send_point(-18'sd1, 18'sd0, 1'b0);
      send_point(18'sd1, 18'sd0, 1'b0);
      send_point(18'sd1, 18'sd0, 1'b0);
      send_point(-18'sd131072, 18'sd0, 1'b1);
      wait_idle();
   endtask

   // zero range: nothing is strictly closer, both sides report zero
   task automatic test_range_zero();
      write_range(17'd0);
      send_point(18'sd5, 18'sd0, 1'b0);
      send_point(-18'sd3, 18'sd0, 1'b1);
      wait_idle();
   endtask

   // range of one: even the origin-adjacent point ties and is dropped
   task automatic test_range_one();
      write_range(17'd1);
      send_point(18'sd1, 18'sd0, 1'b0);
      send_point(18'sd0, 18'sd0, 1'b0);
      send_point(-18'sd1, 18'sd0, 1'b1);
      wait_idle();
   endtask

   // a range write in the middle of a scan restarts it
   task automatic test_write_mid_scan();
      write_range(17'd1000);
      send_point(18'sd10, 18'sd0, 1'b0);
      send_point(-18'sd600, 18'sd800, 1'b0);
      write_range(17'd2000);
      send_point(-18'sd20, 18'sd0, 1'b1);
      wait_idle();
   endtask

   // random scans of mostly short length, with occasional range changes
   task automatic test_random_scans(int n_points, int idle_pct, int stall,
                                    logic [OOR_BITS-1:0] start_range);
      int sent;
      int len;
      int pick;
      write_range(start_range);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      sent = 0;
      while (sent < n_points) begin
         pick = $urandom_range(99);
         if (pick < 80)
            len = $urandom_range(1, 8);
         else
            len = $urandom_range(9, 40);
         for (int i = 0; i < len; i++) begin
            send_point(pick_coord(range_mm), pick_coord(range_mm), i == len - 1);
            sent++;
            if (i != len - 1 && $urandom_range(199) == 0)
               write_range(17'($urandom_range(1, 131071)));
         end
         if ($urandom_range(99) < 4)
            write_range(17'($urandom_range(1, 131071)));
      end
      wait_idle();
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      req_ch.valid      <= 1'b0;
      req_ch.point_x    <= '0;
      req_ch.point_y    <= '0;
      req_ch.last_point <= 1'b0;
      csr_we            <= 1'b0;
      csr_wdata         <= '0;
      range_mm = OOR_RESET;
      reload_minima();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_scan();
      test_coordinate_extremes();
      test_range_zero();
      test_range_one();
      test_write_mid_scan();

      test_random_scans(460, 0, 0, 17'd131071);
      test_random_scans(460, 55, 0, 17'($urandom_range(1, 131071)));
      test_random_scans(460, 0, 55, 17'd2000);
      test_random_scans(460, 25, 25, 17'($urandom_range(1, 131071)));

      // drain and let any trailing word show up
      wait_idle();
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- closest_front_back_range.f -----
sv/cfbr_pkg.sv
sv/cfbr_req_if.sv
sv/cfbr_rsp_if.sv
sv/cfbr_ctrl.sv
sv/cfbr_isqrt.sv
sv/cfbr_dpath.sv
sv/closest_front_back_range.sv
tb/tb.sv
